[hw/rtl/rodq_pkg.sv]
// ----------------------------------------------------------------------------
// rodq_pkg
// Shared types and constants of the ordered-dither RGB quantizer.
// ----------------------------------------------------------------------------
package rodq_pkg;

   localparam int LVL_W  = 4;   // level 0..15 (up to 16 levels)
   localparam int PROD_W = 12;  // v * (L-1), at most 255 * 15
   localparam int REM_W  = 8;   // remainder of division by 255
   localparam int THR_W  = 15;  // (2B+1) * 255, at most 32385
   localparam int BAY_W  = 6;   // Bayer entry 0..63
   localparam int IDX_W  = 8;

   typedef logic [BAY_W-1:0] bayer_entry_type;

   // 8x8 Bayer matrix, indexed by {row[2:0], column[2:0]}
   localparam bayer_entry_type BAYER_TAB [0:63] = '{
      6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
      6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
      6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
      6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
      6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
      6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
      6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
      6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
   };

   // per-stage load enables
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

endpackage

[hw/rtl/rodq_channel.sv]
// ----------------------------------------------------------------------------
// rodq_channel
// One color channel: scale, divide by 255, dither compare and clamp,
// spread over three register stages.
// ----------------------------------------------------------------------------
module rodq_channel import rodq_pkg::*; #(
   parameter int LEVELS = 6
) (
   input  logic               clock,
   input  adv_type            adv,
   input  logic [7:0]         value,
   input  logic [THR_W-1:0]   thr_s2,
   output logic [LVL_W-1:0]   level_s3
);

   localparam logic [LVL_W-1:0] TOP = LVL_W'(LEVELS - 1);

   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [LVL_W-1:0]  lo_ff, lo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [PROD_W:0]   qsum;
   logic [PROD_W-1:0] rem_full;
   logic [LVL_W:0]    lvl_up;
   logic              round_up;

   // stage 1: product
   assign prod_in = PROD_W'(value) * PROD_W'(TOP);

   // stage 2: floor(p/255) = (p + (p>>8) + 1) >> 8 for p below 65535
   always_comb begin
      qsum     = (PROD_W+1)'(prod_ff) + (PROD_W+1)'(prod_ff >> 8) + (PROD_W+1)'(1);
      lo_in    = qsum[LVL_W+7:8];
      rem_full = prod_ff - {lo_in, 8'd0} + PROD_W'(lo_in);
      rem_in   = rem_full[REM_W-1:0];
   end

   // stage 3: round up when rem*128 > (2B+1)*255, then clamp
   always_comb begin
      round_up = {rem_ff, 7'd0} > thr_s2;
      lvl_up   = (LVL_W+1)'(lo_ff) + (LVL_W+1)'(round_up);
      lvl_in   = (lvl_up > (LVL_W+1)'(TOP)) ? TOP : lvl_up[LVL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         prod_ff <= prod_in;
      end
      if (adv.s2) begin
         lo_ff  <= lo_in;
         rem_ff <= rem_in;
      end
      if (adv.s3) begin
         lvl_ff <= lvl_in;
      end
   end

   assign level_s3 = lvl_ff;

endmodule

[hw/rtl/rodq_pack.sv]
// ----------------------------------------------------------------------------
// rodq_pack
// Packs three channel levels into one palette index (low 8 bits kept).
// ----------------------------------------------------------------------------
module rodq_pack import rodq_pkg::*; #(
   parameter int GREEN_LEVELS = 6,
   parameter int BLUE_LEVELS  = 6
) (
   input  logic               clock,
   input  logic               load,
   input  logic [LVL_W-1:0]   red_level,
   input  logic [LVL_W-1:0]   green_level,
   input  logic [LVL_W-1:0]   blue_level,
   output logic [IDX_W-1:0]   palette_index
);

   localparam logic [15:0] GB_MUL = 16'(GREEN_LEVELS * BLUE_LEVELS);
   localparam logic [15:0] B_MUL  = 16'(BLUE_LEVELS);

   logic [15:0]      packed_full;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      packed_full = 16'(red_level) * GB_MUL + 16'(green_level) * B_MUL
                  + 16'(blue_level);
      idx_in      = packed_full[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         idx_ff <= idx_in;
      end
   end

   assign palette_index = idx_ff;

endmodule

[hw/rtl/rgb_ordered_dither_quantizer.sv]
// ----------------------------------------------------------------------------
// rgb_ordered_dither_quantizer
// Ordered (8x8 Bayer) dither of an RGB pixel to a packed palette index.
// ----------------------------------------------------------------------------
// One pixel item is taken per clock while req_stall is low, and its palette
// index passes through four register stages: channel scaling, division by 255,
// dither compare with clamp, and index packing. Each stage holds its item
// only while the stage after it is full and held, so a stall on rsp_ fills
// the empty stages before req_stall rises, and sustained throughput is one
// item per cycle whenever rsp_stall is low.
module rgb_ordered_dither_quantizer import rodq_pkg::*; #(
   parameter int RED_LEVELS   = 6,
   parameter int GREEN_LEVELS = 6,
   parameter int BLUE_LEVELS  = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_red_value,
   input  logic [7:0]       req_green_value,
   input  logic [7:0]       req_blue_value,
   input  logic [11:0]      req_pixel_column,
   input  logic [11:0]      req_pixel_row,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [IDX_W-1:0] rsp_palette_index
);

   adv_type           adv;
   logic [3:0]        vld_ff, vld_in;
   logic [THR_W-1:0]  thr_s1_ff, thr_s1_in;
   logic [THR_W-1:0]  thr_s2_ff;
   bayer_entry_type   bayer;
   logic [THR_W-1:0]  odd_b;
   logic [LVL_W-1:0]  red_lvl, green_lvl, blue_lvl;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      adv.s4 = !vld_ff[3] || !rsp_stall;
      adv.s3 = !vld_ff[2] || adv.s4;
      adv.s2 = !vld_ff[1] || adv.s3;
      adv.s1 = !vld_ff[0] || adv.s2;
      vld_in = vld_ff;
      if (adv.s1) vld_in[0] = req_valid;
      if (adv.s2) vld_in[1] = vld_ff[0];
      if (adv.s3) vld_in[2] = vld_ff[1];
      if (adv.s4) vld_in[3] = vld_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // threshold (2B+1)*255 = x*256 - x
   always_comb begin
      bayer     = BAYER_TAB[{req_pixel_row[2:0], req_pixel_column[2:0]}];
      odd_b     = THR_W'({bayer, 1'b1});
      thr_s1_in = (odd_b << 8) - odd_b;
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         thr_s1_ff <= thr_s1_in;
      end
      if (adv.s2) begin
         thr_s2_ff <= thr_s1_ff;
      end
   end

   rodq_channel #(.LEVELS(RED_LEVELS)) u_red (
      .clock    (clock),
      .adv      (adv),
      .value    (req_red_value),
      .thr_s2   (thr_s2_ff),
      .level_s3 (red_lvl)
   );

   rodq_channel #(.LEVELS(GREEN_LEVELS)) u_green (
      .clock    (clock),
      .adv      (adv),
      .value    (req_green_value),
      .thr_s2   (thr_s2_ff),
      .level_s3 (green_lvl)
   );

   rodq_channel #(.LEVELS(BLUE_LEVELS)) u_blue (
      .clock    (clock),
      .adv      (adv),
      .value    (req_blue_value),
      .thr_s2   (thr_s2_ff),
      .level_s3 (blue_lvl)
   );

   rodq_pack #(
      .GREEN_LEVELS (GREEN_LEVELS),
      .BLUE_LEVELS  (BLUE_LEVELS)
   ) u_pack (
      .clock         (clock),
      .load          (adv.s4),
      .red_level     (red_lvl),
      .green_level   (green_lvl),
      .blue_level    (blue_lvl),
      .palette_index (rsp_palette_index)
   );

   assign req_stall = !adv.s1;
   assign rsp_valid = vld_ff[3];

endmodule

[hw/rtl/rodq_checker.sv]
// ----------------------------------------------------------------------------
// rodq_checker
// Port-level checks of the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module rodq_checker import rodq_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [IDX_W-1:0] rsp_palette_index
);

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_palette_index))
      else $error("stalled result changed");

   // input only backs up when the output is full and held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule

bind rgb_ordered_dither_quantizer rodq_checker u_rodq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_palette_index (rsp_palette_index)
);

[tb/rgb_ordered_dither_quantizer_tb.sv]
// ----------------------------------------------------------------------------
// rgb_ordered_dither_quantizer_tb
// Streams pixel items through the ordered-dither quantizer and checks every
// palette index against a local model of the 8x8 Bayer threshold, per-channel
// quantization and index packing. The sender runs in bursts with gaps and the
// receiver stalls in runs, with stretches free of both.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_ordered_dither_quantizer_tb import rodq_pkg::*;;

   localparam int unsigned RED_LEVELS   = 6;
   localparam int unsigned GREEN_LEVELS = 6;
   localparam int unsigned BLUE_LEVELS  = 6;
   localparam int unsigned RANDOM_ITEMS = 1600;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [11:0] column;
      logic [11:0] row;
      logic        wait_drain;   // hold this item until the pipe is empty
   } pixel_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_red_value = '0;
   logic [7:0]       req_green_value = '0;
   logic [7:0]       req_blue_value = '0;
   logic [11:0]      req_pixel_column = '0;
   logic [11:0]      req_pixel_row = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [IDX_W-1:0] rsp_palette_index;

   pixel_item_type   pixel_q[$];
   logic [7:0]       index_expect_q[$];
   logic             drained = 1'b1;
   int               fail_count = 0;

   int unsigned      burst_left = 0;
   int unsigned      gap_left = 0;
   int unsigned      stall_left = 0;
   logic             stall_run = 1'b0;

   rgb_ordered_dither_quantizer #(
      .RED_LEVELS   (RED_LEVELS),
      .GREEN_LEVELS (GREEN_LEVELS),
      .BLUE_LEVELS  (BLUE_LEVELS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_red_value     (req_red_value),
      .req_green_value   (req_green_value),
      .req_blue_value    (req_blue_value),
      .req_pixel_column  (req_pixel_column),
      .req_pixel_row     (req_pixel_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_palette_index (rsp_palette_index)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bayer entry by bit interleave: bit-reversed {row^col, row} pairs
   function automatic int unsigned bayer_threshold(logic [2:0] row, logic [2:0] col);
      logic [2:0] mix;
      mix = row ^ col;
      return {mix[0], row[0], mix[1], row[1], mix[2], row[2]};
   endfunction

   function automatic int unsigned dither_level(int unsigned v, int unsigned levels,
                                                int unsigned thr);
      int unsigned top;
      int unsigned prod;
      int unsigned lvl;
      top  = levels - 1;
      prod = v * top;
      lvl  = prod / 255;
      // fraction rem/255 against (thr + 0.5)/64, cross-multiplied
      if ((prod % 255) * 128 > (2 * thr + 1) * 255)
         lvl = lvl + 1;
      if (lvl > top)
         lvl = top;
      return lvl;
   endfunction

   function automatic logic [7:0] predict_palette_index(logic [7:0] red, logic [7:0] green,
                                                        logic [7:0] blue, logic [11:0] column,
                                                        logic [11:0] row);
      int unsigned thr;
      int unsigned idx;
      thr = bayer_threshold(row[2:0], column[2:0]);
      idx = dither_level(red, RED_LEVELS, thr) * GREEN_LEVELS * BLUE_LEVELS
          + dither_level(green, GREEN_LEVELS, thr) * BLUE_LEVELS
          + dither_level(blue, BLUE_LEVELS, thr);
      return idx[7:0];
   endfunction

   function automatic logic [7:0] pick_intensity();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom_range(0, 3));
         3:       return 8'($urandom_range(252, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                            logic [11:0] column, logic [11:0] row, logic wait_drain);
      pixel_item_type item;
      item.red        = red;
      item.green      = green;
      item.blue       = blue;
      item.column     = column;
      item.row        = row;
      item.wait_drain = wait_drain;
      pixel_q.push_back(item);
   endtask

   // Driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      pixel_item_type nxt;
      logic           take;
      if (!reset && (!req_valid || !req_stall)) begin
         take = 1'b0;
         if (gap_left != 0)
            gap_left--;
         else if (pixel_q.size() != 0 &&
                  (!pixel_q[0].wait_drain || (drained && !req_valid)))
            take = 1'b1;
         if (take) begin
            nxt = pixel_q.pop_front();
            req_red_value    <= nxt.red;
            req_green_value  <= nxt.green;
            req_blue_value   <= nxt.blue;
            req_pixel_column <= nxt.column;
            req_pixel_row    <= nxt.row;
            if (burst_left == 0)
               burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
         req_valid <= take;
      end
   end

   // Monitor: records accepted items, checks results, drives the stall pattern
   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (index_expect_q.size() == 0) begin
               $error("palette_index: no item pending, actual %0d", rsp_palette_index);
               fail_count++;
            end else begin
               want = index_expect_q.pop_front();
               if (rsp_palette_index !== want) begin
                  $error("palette_index: expected %0d, actual %0d", want, rsp_palette_index);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            index_expect_q.push_back(predict_palette_index(req_red_value, req_green_value,
                                                           req_blue_value, req_pixel_column,
                                                           req_pixel_row));
         drained <= (index_expect_q.size() == 0);
      end
      if (stall_left == 0) begin
         stall_run = ~stall_run;
         if (stall_run)
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25)
                                                     : $urandom_range(1, 4);
         else
            stall_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 12);
      end
      stall_left--;
      rsp_stall <= stall_run;
   end

   initial begin
      int unsigned  k;
      int unsigned  spin;
      logic [11:0]  scan_col;
      logic [11:0]  scan_row;
      logic [11:0]  column;
      logic [11:0]  row;

      // extremes, rounding edges and coordinate aliasing
      add_pixel(8'd0,   8'd0,   8'd0,   12'd0,    12'd0,    1'b0);
      add_pixel(8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, 1'b0);
      add_pixel(8'd255, 8'd255, 8'd255, 12'd0,    12'd0,    1'b0);
      add_pixel(8'd255, 8'd0,   8'd255, 12'd7,    12'd0,    1'b0);
      add_pixel(8'd0,   8'd255, 8'd0,   12'd0,    12'd7,    1'b0);
      // smallest fraction: rounds up only at the lowest threshold
      add_pixel(8'd1,   8'd1,   8'd1,   12'd0,    12'd0,    1'b0);
      add_pixel(8'd1,   8'd1,   8'd1,   12'd0,    12'd7,    1'b0);
      // largest fraction below full scale: rounds up except at the top threshold
      add_pixel(8'd254, 8'd254, 8'd254, 12'd0,    12'd7,    1'b0);
      add_pixel(8'd254, 8'd254, 8'd254, 12'd4,    12'd4,    1'b0);
      // exact level values leave no remainder
      add_pixel(8'd51,  8'd102, 8'd153, 12'd0,    12'd0,    1'b0);
      add_pixel(8'd204, 8'd51,  8'd0,   12'd5,    12'd3,    1'b0);
      // half way between levels at several thresholds
      add_pixel(8'd25,  8'd76,  8'd127, 12'd1,    12'd1,    1'b0);
      add_pixel(8'd26,  8'd77,  8'd128, 12'd2,    12'd6,    1'b0);
      add_pixel(8'd128, 8'd128, 8'd128, 12'd3,    12'd2,    1'b0);
      // upper coordinate bits are ignored
      add_pixel(8'd128, 8'd128, 8'd128, 12'hFFB,  12'hFFA,  1'b0);
      add_pixel(8'd100, 8'd200, 8'd50,  12'hAAA,  12'h555,  1'b0);
      add_pixel(8'd100, 8'd200, 8'd50,  12'h002,  12'h005,  1'b0);
      add_pixel(8'hAA,  8'h55,  8'hAA,  12'h555,  12'hAAA,  1'b0);
      add_pixel(8'h55,  8'hAA,  8'h55,  12'hFF8,  12'h007,  1'b0);
      add_pixel(8'd127, 8'd170, 8'd85,  12'h800,  12'h800,  1'b0);

      scan_col = 12'($urandom_range(0, 4095));
      scan_row = 12'($urandom_range(0, 4095));
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if ($urandom_range(0, 1) == 0) begin
            column = 12'($urandom_range(0, 4095));
            row    = 12'($urandom_range(0, 4095));
         end else begin
            // raster scan in rows of 64 pixels
            column   = scan_col;
            row      = scan_row;
            scan_col = scan_col + 1;
            if (scan_col[5:0] == 6'd0)
               scan_row = scan_row + 1;
         end
         add_pixel(pick_intensity(), pick_intensity(), pick_intensity(), column, row,
                   (k == 0) || ($urandom_range(0, 299) == 0));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pixel_q.size() != 0 || req_valid)
         @(posedge clock);
      spin = 0;
      while (!drained && spin < 2000) begin
         @(posedge clock);
         spin++;
      end
      repeat (20) @(posedge clock);
      if (index_expect_q.size() != 0) begin
         $error("palette_index: %0d items never produced a result", index_expect_q.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
hw/rtl/rodq_pkg.sv
hw/rtl/rodq_channel.sv
hw/rtl/rodq_pack.sv
hw/rtl/rgb_ordered_dither_quantizer.sv
hw/rtl/rodq_checker.sv
tb/rgb_ordered_dither_quantizer_tb.sv
